[rtl/median_filter_3x3_top_assert.svh]
// Assertion macros used by the checker of the 3x3 median filter.
`ifndef MEDIAN_FILTER_3X3_TOP_ASSERT_SVH
`define MEDIAN_FILTER_3X3_TOP_ASSERT_SVH

// Clocked assertion that is switched off while reset is high.
`define MF3_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds while reset is high.
`define MF3_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/mf3_pkg.sv]
// Package with the types, constants and helper functions of the 3x3 median filter.
package mf3_pkg;

  localparam int PIX_W     = 8;
  localparam int FW_W      = 12;
  localparam int FH_W      = 13;
  localparam int COL_W     = 11;
  localparam int ROW_W     = 13;
  localparam int CNT_W     = 23;
  localparam int WH_W      = 24;
  localparam int MAX_WIDTH = 2048;
  localparam int W_MIN     = 3;
  localparam int W_MAX     = (MAX_WIDTH < 2048) ? MAX_WIDTH : 2048;
  localparam int H_MIN     = 3;
  localparam int H_MAX     = 4096;
  localparam int FW_RESET  = 640;
  localparam int FH_RESET  = 480;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;
  localparam int WIN_N     = 9;
  localparam int CENTER    = 4;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [WIN_N-1:0][PIX_W-1:0] window_t;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic border;
    logic last;
  } mf3_ctl_t;

  typedef struct packed {
    pix_t lo;
    pix_t md;
    pix_t hi;
  } sort3_t;

  function automatic sort3_t sort3(input pix_t a, input pix_t b, input pix_t c);
    pix_t   mn;
    pix_t   mx;
    sort3_t s;
    mn   = (a < b) ? a : b;
    mx   = (a < b) ? b : a;
    s.lo = (mn < c) ? mn : c;
    s.hi = (mx > c) ? mx : c;
    s.md = (mx < c) ? mx : ((mn > c) ? mn : c);
    return s;
  endfunction

  function automatic logic [FW_W-1:0] clamp_w(input logic [FW_W-1:0] v);
    logic [FW_W-1:0] r;
    r = v;
    if (v < FW_W'(W_MIN)) begin
      r = FW_W'(W_MIN);
    end else if (v > FW_W'(W_MAX)) begin
      r = FW_W'(W_MAX);
    end
    return r;
  endfunction

  function automatic logic [FH_W-1:0] clamp_h(input logic [FH_W-1:0] v);
    logic [FH_W-1:0] r;
    r = v;
    if (v < FH_W'(H_MIN)) begin
      r = FH_W'(H_MIN);
    end else if (v > FH_W'(H_MAX)) begin
      r = FH_W'(H_MAX);
    end
    return r;
  endfunction

endpackage

[rtl/mf3_stream_if.sv]
// Stream interfaces that carry input pixels and filtered results.
interface mf3_in_if;
  logic                     valid;
  logic                     ready;
  logic [mf3_pkg::PIX_W-1:0] pixel_in;
  logic                     flush;

  modport source (output valid, output pixel_in, output flush, input ready);
  modport sink (input valid, input pixel_in, input flush, output ready);
endinterface

interface mf3_out_if;
  logic                     valid;
  logic                     ready;
  logic [mf3_pkg::PIX_W-1:0] pixel_out;
  logic                     frame_end;

  modport source (output valid, output pixel_out, output frame_end, input ready);
  modport sink (input valid, input pixel_out, input frame_end, output ready);
endinterface

[rtl/mf3_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module mf3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/mf3_front.sv]
// Position counters, line stores with forwarding, and the 3x3 window register.
module mf3_front (
  input  logic                       clk,
  input  logic                       rst,
  mf3_in_if.sink                     in_stream,
  input  logic [mf3_pkg::FW_W-1:0]   width,
  input  logic [mf3_pkg::FH_W-1:0]   height,
  input  logic [mf3_pkg::WH_W-1:0]   frame_size,
  output mf3_pkg::window_t           win,
  output mf3_pkg::mf3_ctl_t          win_ctl,
  output logic                       win_valid,
  input  logic                       win_ready
);

  logic [mf3_pkg::COL_W-1:0] col;
  logic [mf3_pkg::COL_W-1:0] col_next;
  logic [mf3_pkg::ROW_W-1:0] row;
  logic [mf3_pkg::ROW_W-1:0] row_next;
  logic [mf3_pkg::CNT_W-1:0] out_count;
  logic [mf3_pkg::CNT_W-1:0] out_count_next;

  logic                      en1;
  logic                      en2;
  logic                      accept;
  mf3_pkg::pix_t             px;
  logic [mf3_pkg::FW_W-1:0]  col_inc;
  logic                      wrap;
  logic                      emit;
  logic [mf3_pkg::FW_W-1:0]  ocol;
  logic [mf3_pkg::ROW_W-1:0] orow;
  logic                      border;
  logic [mf3_pkg::WH_W-1:0]  cnt_inc;
  logic                      last;

  logic                      s1_valid;
  logic [mf3_pkg::COL_W-1:0] s1_col;
  mf3_pkg::pix_t             s1_px;
  logic                      s1_emit;
  mf3_pkg::mf3_ctl_t         s1_ctl;
  logic                      s1_fwd;
  mf3_pkg::pix_t             s1_fwd_top;
  mf3_pkg::pix_t             s1_fwd_mid;
  mf3_pkg::pix_t             ram_a_q;
  mf3_pkg::pix_t             ram_b_q;
  mf3_pkg::pix_t             s1_top;
  mf3_pkg::pix_t             s1_mid;
  logic                      ram_we;
  mf3_pkg::window_t          win_next;

  assign en2             = !win_valid || win_ready;
  assign en1             = !s1_valid || en2;
  assign in_stream.ready = en1;
  assign accept          = in_stream.valid && en1;

  assign px      = in_stream.flush ? '0 : in_stream.pixel_in;
  assign col_inc = {1'b0, col} + mf3_pkg::FW_W'(1);
  assign wrap    = col_inc >= width;
  assign emit    = (row >= mf3_pkg::ROW_W'(2)) || ((row == mf3_pkg::ROW_W'(1)) && (col != '0));
  assign ocol    = (col != '0) ? ({1'b0, col} - mf3_pkg::FW_W'(1))
                               : (width - mf3_pkg::FW_W'(1));
  assign orow    = (col != '0) ? (row - mf3_pkg::ROW_W'(1)) : (row - mf3_pkg::ROW_W'(2));
  assign border  = (orow == '0) || (orow >= (height - mf3_pkg::FH_W'(1))) ||
                   (ocol == '0) || (ocol >= (width - mf3_pkg::FW_W'(1)));
  assign cnt_inc = {1'b0, out_count} + mf3_pkg::WH_W'(1);
  assign last    = cnt_inc >= frame_size;

  always_comb begin
    col_next       = col;
    row_next       = row;
    out_count_next = out_count;
    if (accept) begin
      if (wrap) begin
        col_next = '0;
        row_next = row + mf3_pkg::ROW_W'(1);
      end else begin
        col_next = col_inc[mf3_pkg::COL_W-1:0];
      end
      if (emit) begin
        if (last) begin
          col_next       = '0;
          row_next       = '0;
          out_count_next = '0;
        end else begin
          out_count_next = cnt_inc[mf3_pkg::CNT_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      row       <= '0;
      out_count <= '0;
    end else begin
      col       <= col_next;
      row       <= row_next;
      out_count <= out_count_next;
    end
  end

  // The entry just read may be rewritten by the older item in the same cycle.
  assign s1_top = s1_fwd ? s1_fwd_top : ram_a_q;
  assign s1_mid = s1_fwd ? s1_fwd_mid : ram_b_q;
  assign ram_we = s1_valid && en2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en1) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col     <= col;
      s1_px      <= px;
      s1_emit    <= emit;
      s1_ctl     <= '{border: border, last: last};
      s1_fwd     <= s1_valid && (s1_col == col);
      s1_fwd_top <= s1_mid;
      s1_fwd_mid <= s1_px;
    end
  end

  mf3_ram #(
    .WIDTH (mf3_pkg::PIX_W),
    .DEPTH (mf3_pkg::MAX_WIDTH)
  ) u_line_a (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_col),
    .wdata (s1_mid),
    .re    (accept),
    .raddr (col),
    .rdata (ram_a_q)
  );

  mf3_ram #(
    .WIDTH (mf3_pkg::PIX_W),
    .DEPTH (mf3_pkg::MAX_WIDTH)
  ) u_line_b (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_col),
    .wdata (s1_px),
    .re    (accept),
    .raddr (col),
    .rdata (ram_b_q)
  );

  always_comb begin
    win_next = win;
    for (int r = 0; r < 3; r++) begin
      win_next[r*3]   = win[r*3+1];
      win_next[r*3+1] = win[r*3+2];
    end
    win_next[2] = s1_top;
    win_next[5] = s1_mid;
    win_next[8] = s1_px;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_valid <= 1'b0;
      win       <= '0;
    end else if (en2) begin
      win_valid <= s1_valid && s1_emit;
      if (s1_valid) begin
        win <= win_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && s1_valid) begin
      win_ctl <= s1_ctl;
    end
  end

endmodule

[rtl/mf3_median.sv]
// Pipelined median-of-nine network and the output register.
module mf3_median (
  input  logic              clk,
  input  logic              rst,
  input  mf3_pkg::window_t  win,
  input  mf3_pkg::mf3_ctl_t win_ctl,
  input  logic              win_valid,
  output logic              win_ready,
  mf3_out_if.source         out_stream
);

  logic              en_o;
  logic              en4;
  logic              en3;

  logic              s3_valid;
  mf3_pkg::sort3_t   s3_rows [3];
  mf3_pkg::pix_t     s3_center;
  mf3_pkg::mf3_ctl_t s3_ctl;

  logic              s4_valid;
  mf3_pkg::pix_t     s4_lo;
  mf3_pkg::pix_t     s4_md;
  mf3_pkg::pix_t     s4_hi;
  mf3_pkg::pix_t     s4_center;
  mf3_pkg::mf3_ctl_t s4_ctl;

  mf3_pkg::sort3_t   mins;
  mf3_pkg::sort3_t   meds;
  mf3_pkg::sort3_t   maxs;
  mf3_pkg::sort3_t   fin;

  assign en_o      = !out_stream.valid || out_stream.ready;
  assign en4       = !s4_valid || en_o;
  assign en3       = !s3_valid || en4;
  assign win_ready = en3;

  assign mins = mf3_pkg::sort3(s3_rows[0].lo, s3_rows[1].lo, s3_rows[2].lo);
  assign meds = mf3_pkg::sort3(s3_rows[0].md, s3_rows[1].md, s3_rows[2].md);
  assign maxs = mf3_pkg::sort3(s3_rows[0].hi, s3_rows[1].hi, s3_rows[2].hi);
  assign fin  = mf3_pkg::sort3(s4_lo, s4_md, s4_hi);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid         <= 1'b0;
      s4_valid         <= 1'b0;
      out_stream.valid <= 1'b0;
    end else begin
      if (en3) begin
        s3_valid <= win_valid;
      end
      if (en4) begin
        s4_valid <= s3_valid;
      end
      if (en_o) begin
        out_stream.valid <= s4_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && win_valid) begin
      for (int r = 0; r < 3; r++) begin
        s3_rows[r] <= mf3_pkg::sort3(win[r*3], win[r*3+1], win[r*3+2]);
      end
      s3_center <= win[mf3_pkg::CENTER];
      s3_ctl    <= win_ctl;
    end
    if (en4 && s3_valid) begin
      s4_lo     <= mins.hi;
      s4_md     <= meds.md;
      s4_hi     <= maxs.lo;
      s4_center <= s3_center;
      s4_ctl    <= s3_ctl;
    end
    if (en_o && s4_valid) begin
      out_stream.pixel_out <= s4_ctl.border ? s4_center : fin.md;
      out_stream.frame_end <= s4_ctl.last;
    end
  end

endmodule

[rtl/median_filter_3x3_top.sv]
// Top level of the 3x3 median filter with its register port.
//
// The filter takes one pixel per clock and gives one result per clock, while
// the output is not held back, once a frame's lag of one row plus one column
// is filled; each frame is followed by frame_width+1 flush transfers to push
// out the last results. A result is formed through a line store read stage,
// the window register, two compare stages and the output register. The rate
// is set by the two line stores, each read and written once per pixel at the
// current column, with the write of one pixel forwarded to the read of the
// next where both hit the same entry. The stores need no clearing after
// reset: their unwritten entries only ever feed border pixels, which pass
// through unchanged. Registers: frame_width at address 0 and frame_height at
// address 4, each used saturated to its legal range.
module median_filter_3x3_top (
  input  logic                        clk,
  input  logic                        rst,
  mf3_in_if.sink                      in_stream,
  mf3_out_if.source                   out_stream,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mf3_pkg::ADDR_W-1:0]  paddr,
  input  logic [mf3_pkg::DATA_W-1:0]  pwdata,
  output logic [mf3_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  logic [mf3_pkg::FW_W-1:0] frame_width;
  logic [mf3_pkg::FH_W-1:0] frame_height;
  logic [mf3_pkg::FW_W-1:0] width;
  logic [mf3_pkg::FW_W-1:0] width_next;
  logic [mf3_pkg::FH_W-1:0] height;
  logic [mf3_pkg::FH_W-1:0] height_next;
  logic [mf3_pkg::WH_W-1:0] frame_size;
  logic [mf3_pkg::WH_W-1:0] frame_size_next;
  mf3_pkg::reg_idx_t        reg_idx;
  logic                     wr_en;

  mf3_pkg::window_t         win;
  mf3_pkg::mf3_ctl_t        win_ctl;
  logic                     win_valid;
  logic                     win_ready;

  assign pready  = 1'b1;
  assign reg_idx = mf3_pkg::reg_idx_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx)
      mf3_pkg::REG_FRAME_WIDTH:  prdata = {{(mf3_pkg::DATA_W-mf3_pkg::FW_W){1'b0}}, frame_width};
      mf3_pkg::REG_FRAME_HEIGHT: prdata = {{(mf3_pkg::DATA_W-mf3_pkg::FH_W){1'b0}}, frame_height};
    endcase
  end

  // The saturated sizes and the frame size follow each write at once.
  always_comb begin
    width_next  = width;
    height_next = height;
    if (wr_en) begin
      unique case (reg_idx)
        mf3_pkg::REG_FRAME_WIDTH:  width_next  = mf3_pkg::clamp_w(pwdata[mf3_pkg::FW_W-1:0]);
        mf3_pkg::REG_FRAME_HEIGHT: height_next = mf3_pkg::clamp_h(pwdata[mf3_pkg::FH_W-1:0]);
      endcase
    end
    frame_size_next = mf3_pkg::WH_W'(width_next) * mf3_pkg::WH_W'(height_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= mf3_pkg::FW_W'(mf3_pkg::FW_RESET);
      frame_height <= mf3_pkg::FH_W'(mf3_pkg::FH_RESET);
      width        <= mf3_pkg::FW_W'(mf3_pkg::FW_RESET);
      height       <= mf3_pkg::FH_W'(mf3_pkg::FH_RESET);
      frame_size   <= mf3_pkg::WH_W'(mf3_pkg::FW_RESET * mf3_pkg::FH_RESET);
    end else begin
      if (wr_en) begin
        unique case (reg_idx)
          mf3_pkg::REG_FRAME_WIDTH:  frame_width  <= pwdata[mf3_pkg::FW_W-1:0];
          mf3_pkg::REG_FRAME_HEIGHT: frame_height <= pwdata[mf3_pkg::FH_W-1:0];
        endcase
      end
      width      <= width_next;
      height     <= height_next;
      frame_size <= frame_size_next;
    end
  end

  mf3_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_stream  (in_stream),
    .width      (width),
    .height     (height),
    .frame_size (frame_size),
    .win        (win),
    .win_ctl    (win_ctl),
    .win_valid  (win_valid),
    .win_ready  (win_ready)
  );

  mf3_median u_median (
    .clk        (clk),
    .rst        (rst),
    .win        (win),
    .win_ctl    (win_ctl),
    .win_valid  (win_valid),
    .win_ready  (win_ready),
    .out_stream (out_stream)
  );

endmodule

[rtl/mf3_checker.sv]
// Port-level checker for the 3x3 median filter and its bind to the top level.
`include "median_filter_3x3_top_assert.svh"

module mf3_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [mf3_pkg::PIX_W-1:0]   pixel_out,
  input logic                        frame_end,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [mf3_pkg::ADDR_W-1:0]  paddr,
  input logic [mf3_pkg::DATA_W-1:0]  pwdata,
  input logic [mf3_pkg::DATA_W-1:0]  prdata,
  input logic                        pready
);

  `MF3_ASSERT_RST(a_pready_high, pready, "pready dropped")

  `MF3_ASSERT_RST(a_reset_empties, rst |=> !out_valid, "result offered straight after reset")

  `MF3_ASSERT_CLK(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(pixel_out) && $stable(frame_end)), "stalled result changed")

  `MF3_ASSERT_CLK(a_cfg_readback, (!$past(rst) && $past(psel && penable && pwrite && pready) && (paddr == $past(paddr))) |-> (prdata == (paddr[2] ? {19'd0, $past(pwdata[12:0])} : {20'd0, $past(pwdata[11:0])})), "register read does not return the written value")

endmodule

bind median_filter_3x3_top mf3_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_stream.valid),
  .out_ready (out_stream.ready),
  .pixel_out (out_stream.pixel_out),
  .frame_end (out_stream.frame_end),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata),
  .pready    (pready)
);
